@@ rtl/assert_macros.svh @@
// Assertion macros for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with synchronous reset as disable condition.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same, with no disable condition.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/tpt_pkg.sv @@
// Shared constants for the TLB page table translator.
`default_nettype none

package tpt_pkg;

  // Fixed field widths at the block ports
  localparam int VA_W    = 16;
  localparam int PA_W    = 16;
  localparam int FRAME_W = 8;

  // Default geometry
  localparam int DEF_PAGE_BITS   = 8;
  localparam int DEF_OFFSET_BITS = 8;
  localparam int DEF_TLB_ENTRIES = 16;

endpackage

`default_nettype wire

@@ rtl/tpt_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none

module tpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/tpt_tlb.sv @@
// Fully associative TLB with fill count and FIFO replacement.
`default_nettype none

module tpt_tlb #(
  parameter int PAGE_BITS   = 8,
  parameter int TLB_ENTRIES = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [PAGE_BITS-1:0] lookup_page,
  output logic                      lookup_hit,
  output logic      [PAGE_BITS-1:0] lookup_frame,
  input  wire logic                 fill_en,
  input  wire logic [PAGE_BITS-1:0] fill_frame
);

  localparam int IW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int CW = $clog2(TLB_ENTRIES + 1);

  logic [PAGE_BITS-1:0] tag   [TLB_ENTRIES];
  logic [PAGE_BITS-1:0] frame [TLB_ENTRIES];
  logic [CW-1:0]        fill_count;
  logic [IW-1:0]        oldest;

  logic [TLB_ENTRIES-1:0] match;
  logic                   full;
  logic [IW-1:0]          slot;

  // Only slots below the fill count are valid; entries are unique, so OR the hits
  always_comb begin
    lookup_frame = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      match[i] = (CW'(i) < fill_count) && (tag[i] == lookup_page);
      if (match[i]) begin
        lookup_frame = lookup_frame | frame[i];
      end
    end
  end

  assign lookup_hit = |match;
  assign full       = (fill_count == CW'(TLB_ENTRIES));
  assign slot       = full ? oldest : fill_count[IW-1:0];

  always_ff @(posedge clk) begin
    if (fill_en) begin
      tag[slot]   <= lookup_page;
      frame[slot] <= fill_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      oldest     <= '0;
    end else if (fill_en) begin
      if (!full) begin
        fill_count <= fill_count + CW'(1);
      end else if (oldest == IW'(TLB_ENTRIES - 1)) begin
        oldest <= '0;
      end else begin
        oldest <= oldest + IW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/tlb_page_table_translator.sv @@
// Top level: TLB lookup in front of a demand-paged page table.
//
// At the accepting edge the address is registered and the page table RAM is
// read at its page; busy is high the next cycle, while the TLB is searched,
// the RAM word is used on a miss and a new frame is assigned on a fault; at
// the end of that cycle the TLB is filled on a miss and the page table is
// written on a fault. The result then shows for one cycle with done high and
// must be taken then, as the receiver cannot stall the block; in that same
// cycle busy is low and the next request may be accepted. The registered page
// table read and the read-after-update dependency set this schedule. The
// mapped bits all clear together at reset, so requests are taken right away.
`default_nettype none

module tlb_page_table_translator #(
  parameter int PAGE_BITS   = tpt_pkg::DEF_PAGE_BITS,
  parameter int OFFSET_BITS = tpt_pkg::DEF_OFFSET_BITS,
  parameter int TLB_ENTRIES = tpt_pkg::DEF_TLB_ENTRIES
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [tpt_pkg::VA_W-1:0]   virtual_address,
  output logic                            done,
  output logic      [tpt_pkg::PA_W-1:0]   physical_address,
  output logic      [tpt_pkg::FRAME_W-1:0] frame_index,
  output logic                            tlb_hit,
  output logic                            frame_assigned
);

  import tpt_pkg::*;

  localparam int NPAGES = 1 << PAGE_BITS;
  localparam int EXT_W  = VA_W + OFFSET_BITS + PAGE_BITS;
  localparam int PAX_W  = PAGE_BITS + OFFSET_BITS + PA_W;
  localparam int FX_W   = PAGE_BITS + FRAME_W;

  logic                   accept;
  logic [VA_W-1:0]        va_q;
  logic [EXT_W-1:0]       in_ext;
  logic [EXT_W-1:0]       va_ext;
  logic [PAGE_BITS-1:0]   in_page;
  logic [PAGE_BITS-1:0]   page;
  logic [OFFSET_BITS-1:0] offset;

  logic [NPAGES-1:0]      page_mapped;
  logic [PAGE_BITS:0]     next_free_frame;
  logic [PAGE_BITS-1:0]   table_frame;

  logic                   hit;
  logic [PAGE_BITS-1:0]   tlb_frame;
  logic                   mapped;
  logic                   fault;
  logic                   miss;
  logic [PAGE_BITS-1:0]   frame;
  logic [PAX_W-1:0]       pa_ext;
  logic [FX_W-1:0]        fx_ext;

  assign accept  = start && !busy;
  assign in_ext  = EXT_W'(virtual_address);
  assign in_page = in_ext[OFFSET_BITS +: PAGE_BITS];
  assign va_ext  = EXT_W'(va_q);
  assign page    = va_ext[OFFSET_BITS +: PAGE_BITS];
  assign offset  = va_ext[OFFSET_BITS-1:0];

  tpt_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (NPAGES)
  ) u_page_table (
    .clk   (clk),
    .we    (fault),
    .waddr (page),
    .wdata (frame),
    .re    (accept),
    .raddr (in_page),
    .rdata (table_frame)
  );

  tpt_tlb #(
    .PAGE_BITS   (PAGE_BITS),
    .TLB_ENTRIES (TLB_ENTRIES)
  ) u_tlb (
    .clk          (clk),
    .rst          (rst),
    .lookup_page  (page),
    .lookup_hit   (hit),
    .lookup_frame (tlb_frame),
    .fill_en      (miss),
    .fill_frame   (frame)
  );

  assign mapped = page_mapped[page];
  assign miss   = busy && !hit;
  assign fault  = miss && !mapped;

  always_comb begin
    if (hit) begin
      frame = tlb_frame;
    end else if (mapped) begin
      frame = table_frame;
    end else begin
      frame = next_free_frame[PAGE_BITS-1:0];
    end
  end

  assign pa_ext = PAX_W'({frame, offset});
  assign fx_ext = FX_W'(frame);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy            <= 1'b0;
      done            <= 1'b0;
      page_mapped     <= '0;
      next_free_frame <= '0;
    end else begin
      busy <= accept;
      done <= busy;
      if (fault) begin
        page_mapped[page] <= 1'b1;
        next_free_frame   <= next_free_frame + (PAGE_BITS + 1)'(1);
      end
    end
  end

  // Hold the request and the result payloads
  always_ff @(posedge clk) begin
    if (accept) begin
      va_q <= virtual_address;
    end
    if (busy) begin
      physical_address <= pa_ext[PA_W-1:0];
      frame_index      <= fx_ext[FRAME_W-1:0];
      tlb_hit          <= hit;
      frame_assigned   <= fault;
    end
  end

endmodule

`default_nettype wire

@@ rtl/tpt_checker.sv @@
// Port-level checker for the translator, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module tpt_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic [tpt_pkg::VA_W-1:0]    virtual_address,
  input wire logic                        done,
  input wire logic [tpt_pkg::PA_W-1:0]    physical_address,
  input wire logic [tpt_pkg::FRAME_W-1:0] frame_index,
  input wire logic                        tlb_hit,
  input wire logic                        frame_assigned
);

  `ASSERT_CLK(a_accept_busy, clk, rst, start && !busy |=> busy, "request taken without busy")
  `ASSERT_CLK(a_busy_done, clk, rst, busy |=> done && !busy, "no result after busy cycle")
  `ASSERT_CLK(a_idle_no_done, clk, rst, !busy |=> !done, "result without a request")
  `ASSERT_CLK(a_hit_no_fault, clk, rst, done |-> !(tlb_hit && frame_assigned), "hit and fault together")
  `ASSERT_ALWAYS(a_reset_clear, clk, rst |=> !busy && !done, "reset left request in flight")

endmodule

bind tlb_page_table_translator tpt_checker u_tpt_checker (
  .clk              (clk),
  .rst              (rst),
  .start            (start),
  .busy             (busy),
  .virtual_address  (virtual_address),
  .done             (done),
  .physical_address (physical_address),
  .frame_index      (frame_index),
  .tlb_hit          (tlb_hit),
  .frame_assigned   (frame_assigned)
);

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for the TLB page table translator.
`timescale 1ns / 100ps
`default_nettype none

module tb;

  localparam int VA_W      = tpt_pkg::VA_W;
  localparam int PA_W      = tpt_pkg::PA_W;
  localparam int FRAME_W   = tpt_pkg::FRAME_W;
  localparam int PAGE_W    = tpt_pkg::DEF_PAGE_BITS;
  localparam int OFS_W     = tpt_pkg::DEF_OFFSET_BITS;
  localparam int TLB_DEPTH = tpt_pkg::DEF_TLB_ENTRIES;
  localparam int NUM_PAGES = 1 << PAGE_W;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic [PA_W-1:0]    phys;
    logic [FRAME_W-1:0] frame;
    logic               hit;
    logic               fault;
  } xlat_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic [VA_W-1:0]   virtual_address = '0;
  logic              busy;
  logic              done;
  logic [PA_W-1:0]   physical_address;
  logic [FRAME_W-1:0] frame_index;
  logic              tlb_hit;
  logic              frame_assigned;

  tlb_page_table_translator dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .virtual_address  (virtual_address),
    .done             (done),
    .physical_address (physical_address),
    .frame_index      (frame_index),
    .tlb_hit          (tlb_hit),
    .frame_assigned   (frame_assigned)
  );

  // Predictor state
  logic [PAGE_W-1:0]  tlb_tag_q   [TLB_DEPTH];
  logic [FRAME_W-1:0] tlb_frame_q [TLB_DEPTH];
  logic [4:0]         tlb_count_q;
  logic [3:0]         tlb_victim_q;
  logic [FRAME_W-1:0] frame_of_page [NUM_PAGES];
  logic               page_is_mapped [NUM_PAGES];
  logic [PAGE_W:0]    free_frame_q;

  xlat_t expected_xlats[$];
  xlat_t head_xlat;
  int    fail_count;
  int    mismatch_count;
  int    requests_sent;
  int    results_seen;
  int    hits_predicted;
  int    faults_predicted;
  int    idle_pct;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic xlat_t translate_va(input logic [VA_W-1:0] va);
    xlat_t             r;
    logic [PAGE_W-1:0] page;
    logic [OFS_W-1:0]  ofs;
    logic [FRAME_W-1:0] frm;
    logic              found;
    int                slot;
    page  = va[OFS_W +: PAGE_W];
    ofs   = va[OFS_W-1:0];
    frm   = '0;
    found = 1'b0;
    r     = '0;
    for (int i = 0; i < TLB_DEPTH; i++) begin
      if (!found && i < tlb_count_q && tlb_tag_q[i] == page) begin
        frm   = tlb_frame_q[i];
        found = 1'b1;
      end
    end
    if (!found) begin
      if (page_is_mapped[page]) begin
        frm = frame_of_page[page];
      end else begin
        r.fault              = 1'b1;
        frm                  = free_frame_q[PAGE_W-1:0];
        frame_of_page[page]  = frm;
        page_is_mapped[page] = 1'b1;
        free_frame_q         = free_frame_q + 1'b1;
      end
      // fill empty slots first, then replace in arrival order
      if (tlb_count_q < TLB_DEPTH) begin
        slot        = tlb_count_q;
        tlb_count_q = tlb_count_q + 1'b1;
      end else begin
        slot         = tlb_victim_q;
        tlb_victim_q = tlb_victim_q + 1'b1;
      end
      tlb_tag_q[slot]   = page;
      tlb_frame_q[slot] = frm;
    end
    r.hit   = found;
    r.frame = frm;
    r.phys  = {frm, ofs};
    return r;
  endfunction

  // Hold start until the request is taken, then idle the sender at random.
  task automatic send_request(input logic [VA_W-1:0] va);
    xlat_t e;
    int    gap;
    start           <= 1'b1;
    virtual_address <= va;
    do @(posedge clk); while (busy);
    e = translate_va(va);
    expected_xlats.push_back(e);
    requests_sent++;
    if (e.hit) hits_predicted++;
    if (e.fault) faults_predicted++;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start           <= 1'b0;
      virtual_address <= VA_W'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      results_seen++;
      if (expected_xlats.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_SHOWN) $display("unexpected result pa=%h", physical_address);
      end else begin
        head_xlat = expected_xlats.pop_front();
        if (physical_address !== head_xlat.phys || frame_index !== head_xlat.frame ||
            tlb_hit !== head_xlat.hit || frame_assigned !== head_xlat.fault) begin
          mismatch_count++;
          fail_count++;
          if (mismatch_count <= MAX_SHOWN) begin
            $display("mismatch: exp pa=%h frame=%h hit=%b fault=%b, got pa=%h frame=%h hit=%b fault=%b",
                     head_xlat.phys, head_xlat.frame, head_xlat.hit, head_xlat.fault,
                     physical_address, frame_index, tlb_hit, frame_assigned);
          end
        end
      end
    end
  end

  task automatic test_page_zero_after_reset();
    send_request(16'h0000);
    send_request(16'h00ff);
    send_request(16'hffff);
    send_request(16'hff00);
  endtask

  // Fill the TLB, evict, then revisit an evicted but still mapped page.
  task automatic test_fill_and_evict();
    for (int p = 8'h10; p <= 8'h1d; p++) send_request({p[7:0], 8'($urandom)});
    send_request(16'h1e80);
    send_request(16'h0055);
    send_request(16'h1aaa);
  endtask

  // A hit must not refresh the replacement order.
  task automatic test_hit_keeps_order();
    send_request(16'h1033);
    send_request(16'h1f01);
    send_request(16'h1012);
  endtask

  task automatic test_random_traffic(input int count, input int pct);
    logic [PAGE_W-1:0] base;
    logic [PAGE_W-1:0] page;
    idle_pct = pct;
    base     = PAGE_W'($urandom);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 3) base = PAGE_W'($urandom);
      // a working set a little wider than the TLB gives hits, evictions and refills
      if ($urandom_range(99) < 70) page = base + PAGE_W'($urandom_range(23));
      else page = PAGE_W'($urandom);
      send_request({page, OFS_W'($urandom)});
    end
  endtask

  initial begin
    int guard;
    fail_count       = 0;
    mismatch_count   = 0;
    requests_sent    = 0;
    results_seen     = 0;
    hits_predicted   = 0;
    faults_predicted = 0;
    idle_pct         = 0;
    tlb_count_q      = '0;
    tlb_victim_q     = '0;
    free_frame_q     = '0;
    for (int i = 0; i < NUM_PAGES; i++) page_is_mapped[i] = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    idle_pct = 33;
    test_page_zero_after_reset();
    test_fill_and_evict();
    test_hit_keeps_order();
    test_random_traffic(600, 33);
    test_random_traffic(600, 65);
    test_random_traffic(600, 0);

    @(posedge clk);
    start <= 1'b0;
    guard = 0;
    while (expected_xlats.size() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (6) @(posedge clk);
    if (expected_xlats.size() != 0) begin
      fail_count++;
      $display("%0d results never arrived", expected_xlats.size());
    end
    $display("sent %0d translations, %0d results checked, %0d mismatches",
             requests_sent, results_seen, mismatch_count);
    $display("expected %0d TLB hits and %0d page faults (%0d frames handed out)",
             hits_predicted, faults_predicted, free_frame_q);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
